// ===== hw/rtl/tbve_pkg.sv =====
// Shared types, constants and the power-of-ten table for the two-button value editor.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package tbve_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int BTN_W       = $clog2(NUM_BUTTONS);
  localparam int TICKS_W     = 16;
  localparam int WAIT_W      = 14;
  localparam int DIGIT_W     = 4;
  localparam int VALUE_W     = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic [BTN_W-1:0] BTN_OK    = BTN_W'(0);
  localparam logic [BTN_W-1:0] BTN_BREAK = BTN_W'(1);

  localparam logic [DIGIT_W-1:0] DIGIT_LAST = DIGIT_W'(9);

  localparam logic [TICKS_W-1:0] CLICK_TICKS_RESET     = TICKS_W'(10);
  localparam logic [TICKS_W-1:0] HOLD_TICKS_RESET      = TICKS_W'(1000);
  localparam logic [WAIT_W-1:0]  RELEASE_TIMEOUT_RESET = WAIT_W'(10000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TICKS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_LIMIT     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX       = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE     = CFG_IDX_W'(6);

  typedef enum logic [MODE_W-1:0] {
    MODE_MENU     = 2'd0,
    MODE_POSITION = 2'd1,
    MODE_EDIT     = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TICKS_W-1:0]        click_ticks;
    logic [TICKS_W-1:0]        hold_ticks;
    logic [WAIT_W-1:0]         release_timeout;
    logic [DIGIT_W-1:0]        digit_limit;
    logic signed [VALUE_W-1:0] value_min;
    logic signed [VALUE_W-1:0] value_max;
    logic signed [VALUE_W-1:0] start_value;
  } cfg_t;

  // Per-button view after this tick's level update
  typedef struct packed {
    logic pressed;
    logic click;
    logic hold;
  } btn_stat_t;

  typedef struct packed {
    mode_t                     mode;
    logic [DIGIT_W-1:0]        digit;
    logic signed [VALUE_W-1:0] value;
    logic                      go_next;
    logic                      go_previous;
    logic                      go_child;
    logic                      go_parent;
  } res_t;

  // Step size for a digit position; positions past nine use the top entry
  function automatic logic [VALUE_W-1:0] pow10(input logic [DIGIT_W-1:0] d);
    logic [VALUE_W-1:0] p;
    case (d)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      default: p = 32'd1000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tbve_if.sv =====
// Handshake channel interfaces of the two-button value editor: tick requests,
// result requests and configuration writes. Widths come from tbve_pkg.
`default_nettype none

interface tbve_tick_if;
  logic valid;
  logic ready;
  logic ok_pressed;
  logic break_pressed;
  logic child_is_editable;

  modport source (output valid, ok_pressed, break_pressed, child_is_editable, input ready);
  modport sink   (input valid, ok_pressed, break_pressed, child_is_editable, output ready);
endinterface

interface tbve_result_if;
  logic                                valid;
  logic                                ready;
  logic [tbve_pkg::MODE_W-1:0]         mode;
  logic [tbve_pkg::DIGIT_W-1:0]        digit_pos;
  logic signed [tbve_pkg::VALUE_W-1:0] edited_value;
  logic                                go_next;
  logic                                go_previous;
  logic                                go_child;
  logic                                go_parent;

  modport source (output valid, mode, digit_pos, edited_value, go_next, go_previous,
                  go_child, go_parent, input ready);
  modport sink   (input valid, mode, digit_pos, edited_value, go_next, go_previous,
                  go_child, go_parent, output ready);
endinterface

interface tbve_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbve_pkg::CFG_IDX_W-1:0]    index;
  logic [tbve_pkg::VALUE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tbve_cfg.sv =====
// Configuration register file of the two-button value editor.
// Depends on tbve_pkg and the tbve_cfg_if interface.
`default_nettype none

module tbve_cfg (
  input  logic           clk,
  input  logic           rst,
  tbve_cfg_if.sink       cfg,
  output tbve_pkg::cfg_t regs
);
  import tbve_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.click_ticks     <= CLICK_TICKS_RESET;
      regs.hold_ticks      <= HOLD_TICKS_RESET;
      regs.release_timeout <= RELEASE_TIMEOUT_RESET;
      regs.digit_limit     <= '0;
      regs.value_min       <= '0;
      regs.value_max       <= '0;
      regs.start_value     <= '0;
    end else if (wr) begin
      unique case (cfg.index)
        CFG_CLICK_TICKS:     regs.click_ticks     <= cfg.data[TICKS_W-1:0];
        CFG_HOLD_TICKS:      regs.hold_ticks      <= cfg.data[TICKS_W-1:0];
        CFG_RELEASE_TIMEOUT: regs.release_timeout <= cfg.data[WAIT_W-1:0];
        CFG_DIGIT_LIMIT:     regs.digit_limit     <= cfg.data[DIGIT_W-1:0];
        CFG_VALUE_MIN:       regs.value_min       <= $signed(cfg.data);
        CFG_VALUE_MAX:       regs.value_max       <= $signed(cfg.data);
        CFG_START_VALUE:     regs.start_value     <= $signed(cfg.data);
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbve_btn.sv =====
// One button: saturating press counter and last level, with click and hold detect.
// Depends on tbve_pkg.
`default_nettype none

module tbve_btn #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           level,
  input  logic                           clr,
  input  logic [tbve_pkg::TICKS_W-1:0]   click_ticks,
  input  logic [tbve_pkg::TICKS_W-1:0]   hold_ticks,
  output tbve_pkg::btn_stat_t            stat
);
  import tbve_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  pressed;

  // Restart on a new press, saturate at all ones
  always_comb begin
    count_next = count;
    if (level) begin
      if (!pressed) begin
        count_next = COUNT_BITS'(1);
      end else if (!(&count)) begin
        count_next = count + COUNT_BITS'(1);
      end
    end
  end

  assign stat.pressed = level;
  assign stat.click   = !level && (CMP_W'(count_next) >= CMP_W'(click_ticks));
  assign stat.hold    = level && (CMP_W'(count_next) >= CMP_W'(hold_ticks));

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pressed <= 1'b0;
    end else if (en) begin
      count   <= clr ? '0 : count_next;
      pressed <= level;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbve_ctrl.sv =====
// Mode machine, digit and value registers, release wait and navigation pulses.
// Depends on tbve_pkg.
`default_nettype none

module tbve_ctrl (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      child_is_editable,
  input  tbve_pkg::cfg_t                            cfg,
  input  tbve_pkg::btn_stat_t [tbve_pkg::NUM_BUTTONS-1:0] stat,
  output logic [tbve_pkg::NUM_BUTTONS-1:0]          clr,
  output tbve_pkg::res_t                            res
);
  import tbve_pkg::*;

  mode_t                     mode;
  mode_t                     mode_next;
  logic [DIGIT_W-1:0]        digit;
  logic [DIGIT_W-1:0]        digit_up;
  logic [DIGIT_W-1:0]        digit_next;
  logic [DIGIT_W-1:0]        dmax;
  logic signed [VALUE_W-1:0] value;
  logic signed [VALUE_W-1:0] value_ok;
  logic signed [VALUE_W-1:0] value_brk;
  logic signed [VALUE_W-1:0] value_next;
  logic signed [VALUE_W-1:0] vmin;
  logic signed [VALUE_W-1:0] vmax;
  logic signed [VALUE_W:0]   step;
  logic signed [VALUE_W:0]   ok_try;
  logic signed [VALUE_W:0]   brk_try;
  logic                      wait_active;
  logic                      wait_active_next;
  logic [BTN_W-1:0]          wait_button;
  logic [BTN_W-1:0]          wait_button_next;
  logic [WAIT_W-1:0]         wait_count;
  logic [WAIT_W-1:0]         wait_count_next;
  logic [WAIT_W-1:0]         wait_inc;
  logic                      wait_done;
  logic                      ok_click;
  logic                      brk_click;
  logic                      ok_hold;
  logic                      brk_hold;
  logic                      go_next;
  logic                      go_previous;
  logic                      go_child;
  logic                      go_parent;

  assign vmin = $signed(cfg.value_min);
  assign vmax = $signed(cfg.value_max);

  assign wait_inc  = wait_count + WAIT_W'(1);
  assign wait_done = wait_active &&
                     !(stat[wait_button].pressed && (wait_inc < cfg.release_timeout));

  assign ok_click  = !wait_active && stat[BTN_OK].click;
  assign brk_click = !wait_active && stat[BTN_BREAK].click;
  assign ok_hold   = !wait_active && stat[BTN_OK].hold;
  assign brk_hold  = !wait_active && !ok_hold && stat[BTN_BREAK].hold;

  always_comb begin
    clr = '0;
    if (wait_done) clr[wait_button] = 1'b1;
    if (ok_click)  clr[BTN_OK]      = 1'b1;
    if (brk_click) clr[BTN_BREAK]   = 1'b1;
  end

  // Next mode
  always_comb begin
    mode_next = mode;
    if (ok_hold) begin
      unique case (mode)
        MODE_MENU:     if (child_is_editable) mode_next = MODE_POSITION;
        MODE_POSITION: mode_next = MODE_EDIT;
        MODE_EDIT:     mode_next = MODE_POSITION;
        default:       mode_next = mode;
      endcase
    end else if (brk_hold) begin
      unique case (mode)
        MODE_MENU:     mode_next = mode;
        MODE_POSITION: mode_next = MODE_MENU;
        MODE_EDIT:     mode_next = MODE_POSITION;
        default:       mode_next = mode;
      endcase
    end
  end

  // Release wait
  always_comb begin
    wait_active_next = wait_active;
    wait_button_next = wait_button;
    wait_count_next  = wait_active ? wait_inc : wait_count;
    if (wait_done) wait_active_next = 1'b0;
    if (ok_hold || brk_hold) begin
      wait_active_next = 1'b1;
      wait_button_next = ok_hold ? BTN_OK : BTN_BREAK;
      wait_count_next  = '0;
    end
  end

  // Digit, value and pulses
  always_comb begin
    dmax = (cfg.digit_limit > DIGIT_LAST) ? DIGIT_LAST : cfg.digit_limit;
    step = $signed({1'b0, pow10(digit)});

    digit_up = digit;
    if (ok_click && (mode == MODE_POSITION) && (digit < dmax)) begin
      digit_up = digit + DIGIT_W'(1);
    end
    digit_next = digit_up;
    if (brk_click && (mode == MODE_POSITION) && (digit_up != '0)) begin
      digit_next = digit_up - DIGIT_W'(1);
    end

    ok_try   = (value < vmax) ? ({value[VALUE_W-1], value} + step)
                              : {value[VALUE_W-1], value};
    value_ok = value;
    if (ok_click && (mode == MODE_EDIT)) begin
      if ((ok_try > $signed({vmax[VALUE_W-1], vmax})) ||
          (ok_try < $signed({vmin[VALUE_W-1], vmin}))) begin
        value_ok = vmax;
      end else begin
        value_ok = ok_try[VALUE_W-1:0];
      end
    end

    brk_try   = (value_ok > vmin) ? ({value_ok[VALUE_W-1], value_ok} - step)
                                  : {value_ok[VALUE_W-1], value_ok};
    value_brk = value_ok;
    if (brk_click && (mode == MODE_EDIT)) begin
      if ((brk_try > $signed({vmax[VALUE_W-1], vmax})) ||
          (brk_try < $signed({vmin[VALUE_W-1], vmin}))) begin
        value_brk = vmin;
      end else begin
        value_brk = brk_try[VALUE_W-1:0];
      end
    end

    value_next = value_brk;
    if (ok_hold && (mode == MODE_MENU) && child_is_editable) begin
      value_next = $signed(cfg.start_value);
    end

    go_next     = ok_click && (mode == MODE_MENU);
    go_previous = brk_click && (mode == MODE_MENU);
    go_child    = ok_hold && (mode == MODE_MENU) && !child_is_editable;
    go_parent   = brk_hold && (mode == MODE_MENU);
  end

  assign res.mode        = mode_next;
  assign res.digit       = digit_next;
  assign res.value       = value_next;
  assign res.go_next     = go_next;
  assign res.go_previous = go_previous;
  assign res.go_child    = go_child;
  assign res.go_parent   = go_parent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_MENU;
      digit       <= '0;
      value       <= '0;
      wait_active <= 1'b0;
      wait_button <= '0;
      wait_count  <= '0;
    end else if (en) begin
      mode        <= mode_next;
      digit       <= digit_next;
      value       <= value_next;
      wait_active <= wait_active_next;
      wait_button <= wait_button_next;
      wait_count  <= wait_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_button_value_editor.sv =====
// Two-button value editor, top level: input register, per-button counters,
// mode machine and result register. Depends on tbve_pkg, tbve_if, tbve_cfg,
// tbve_btn and tbve_ctrl.
`default_nettype none

// Each tick request carries the OK and BREAK button levels sampled on one
// 1 ms tick plus the child_is_editable flag of the current menu item. The
// block answers every tick with exactly one result request: the mode after
// the tick (menu, digit position, digit edit), the digit position, the edited
// value and the four navigation pulses. Throughput is one tick per clock
// cycle while the result side takes its results. A tick passes through the
// input register, then the result register fed by the single pass through
// the counters and the mode machine. The result register decouples the two
// sides, so a new tick is taken into an empty input register while a
// finished result still waits, and ticks keep flowing as long as the result
// side takes one per cycle. Configuration writes go to cfg at any time the
// block is idle; ready on that channel is always high and writes to unmapped
// indexes are dropped. COUNT_BITS sets the width of the saturating press
// counters.

module two_button_value_editor #(
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  tbve_tick_if.sink     tick,
  tbve_result_if.source result,
  tbve_cfg_if.sink      cfg
);
  import tbve_pkg::*;

  cfg_t                          regs;
  btn_stat_t [NUM_BUTTONS-1:0]   stat;
  logic [NUM_BUTTONS-1:0]        clr;
  logic [NUM_BUTTONS-1:0]        level;
  res_t                          res;

  logic s1_valid;
  logic s1_ok;
  logic s1_brk;
  logic s1_child;
  logic adv;

  logic out_valid;
  res_t out_res;

  // Advance the registered tick whenever the result register is free or drains
  assign adv        = s1_valid && (!out_valid || result.ready);
  assign tick.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_ok    <= tick.ok_pressed;
      s1_brk   <= tick.break_pressed;
      s1_child <= tick.child_is_editable;
    end
  end

  tbve_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign level[BTN_OK]    = s1_ok;
  assign level[BTN_BREAK] = s1_brk;

  // One counter per button
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    tbve_btn #(
      .COUNT_BITS (COUNT_BITS)
    ) u_btn (
      .clk         (clk),
      .rst         (rst),
      .en          (adv),
      .level       (level[b]),
      .clr         (clr[b]),
      .click_ticks (regs.click_ticks),
      .hold_ticks  (regs.hold_ticks),
      .stat        (stat[b])
    );
  end

  tbve_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .en                (adv),
    .child_is_editable (s1_child),
    .cfg               (regs),
    .stat              (stat),
    .clr               (clr),
    .res               (res)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.mode           = out_res.mode;
  assign result.digit_pos      = out_res.digit;
  assign result.edited_value   = out_res.value;
  assign result.go_next        = out_res.go_next;
  assign result.go_previous    = out_res.go_previous;
  assign result.go_child       = out_res.go_child;
  assign result.go_parent      = out_res.go_parent;

endmodule

`default_nettype wire

// ===== hw/rtl/tbve_chk.sv =====
// Port-level assertions for the two-button value editor, bound to the top level.
// Depends on tbve_pkg and two_button_value_editor.
`default_nettype none

module tbve_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                tick_ready,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic [tbve_pkg::MODE_W-1:0]         mode,
  input logic [tbve_pkg::DIGIT_W-1:0]        digit_pos,
  input logic [tbve_pkg::VALUE_W-1:0]        edited_value,
  input logic                                go_next,
  input logic                                go_previous,
  input logic                                go_child,
  input logic                                go_parent
);
  import tbve_pkg::*;

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({mode, digit_pos, edited_value, go_next, go_previous, go_child, go_parent}))
    else $error("result changed while stalled");

  // With an empty result register a tick is always taken
  a_tick_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick_ready)
    else $error("tick refused with result side empty");

  // Child and parent come only from holds in menu mode, never together
  a_nav_menu: assert property (@(posedge clk) disable iff (rst)
    res_valid && (go_child || go_parent) |->
      (mode == MODE_MENU) && !(go_child && go_parent))
    else $error("child/parent pulse outside menu or both at once");

  // Digit position never passes the last decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> digit_pos <= DIGIT_LAST)
    else $error("digit position out of range");

endmodule

bind two_button_value_editor tbve_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .tick_ready     (tick.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .mode           (result.mode),
  .digit_pos      (result.digit_pos),
  .edited_value   (result.edited_value),
  .go_next        (result.go_next),
  .go_previous    (result.go_previous),
  .go_child       (result.go_child),
  .go_parent      (result.go_parent)
);

`default_nettype wire
